// ===== design/ctg_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ctg_pkg: shared types and constants of the chime tone generator
// Holds the chime pattern timing, the sine polynomial coefficients, the
// datapath step codes and the controller to datapath command/status types.
// ----------------------------------------------------------------------------
package ctg_pkg;

    // Chime pattern timing in milliseconds.
    localparam logic [9:0] PAT_LEN      = 10'd760;
    localparam logic [9:0] PULSE_LEN    = 10'd200;
    localparam logic [9:0] SECOND_START = 10'd380;
    localparam logic [9:0] SECOND_END   = 10'd580;
    localparam logic [7:0] FADE_MS      = 8'd20;

    // Envelope in units of 1/2000.
    localparam logic [10:0] ENV_ONE     = 11'd2000;
    localparam logic [10:0] ENV_RISE    = 11'd100;
    localparam logic [10:0] ENV_DECAY   = 11'd7;

    // Volume and amplitude.
    localparam logic [6:0]  VOL_RESET   = 7'd15;
    localparam logic [6:0]  VOL_MAX     = 7'd100;
    localparam logic [12:0] AMP_PER_PCT = 13'd80;
    localparam logic [12:0] MAG_MAX     = 13'd8000;

    // Odd sine polynomial in unsigned Q16.
    localparam logic [16:0] Q16_ONE     = 17'd65536;
    localparam logic [16:0] SIN_K       = 17'd307;
    localparam logic [17:0] SIN_C0      = 18'd5223;
    localparam logic [17:0] SIN_C1      = 18'd42334;
    localparam logic [17:0] SIN_C2      = 18'd102944;

    // Division by 1000 as a multiplication by a rounded-up reciprocal.
    localparam int          DIV_SHIFT   = 35;
    localparam logic [63:0] DIV_RECIP_W = ((64'd1 << DIV_SHIFT) + 64'd999) / 64'd1000;
    localparam logic [25:0] DIV_RECIP   = DIV_RECIP_W[25:0];

    // Datapath steps; the controller walks them in ascending code order.
    typedef logic [2:0] t_op;
    localparam t_op OP_X2  = 3'd0;  // x^2
    localparam t_op OP_T1  = 3'd1;  // inner polynomial term
    localparam t_op OP_T2  = 3'd2;
    localparam t_op OP_T3  = 3'd3;
    localparam t_op OP_S   = 3'd4;  // sine magnitude
    localparam t_op OP_AV  = 3'd5;  // times volume
    localparam t_op OP_AE  = 3'd6;  // times envelope
    localparam t_op OP_DIV = 3'd7;  // divide by 1000 and clamp

    typedef struct packed {
        logic load_tick;
        logic load_trig;
        logic calc;
        t_op  op;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic tone_now;
    } t_dp_status;

endpackage
`default_nettype wire

// ===== design/ctg_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ctg_ctrl: controller of the chime tone generator
// Accepts transactions, steps the datapath through the sample computation and
// owns the valid flag of the output register.
// ----------------------------------------------------------------------------
module ctg_ctrl (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_s_valid,
    input  wire                  i_func,
    output logic                 o_s_ready,
    input  wire                  i_m_ready,
    output logic                 o_m_valid,
    input  ctg_pkg::t_dp_status  i_status,
    output ctg_pkg::t_dp_cmd     o_cmd
);
    import ctg_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CALC = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0] r_state, n_state;
    t_op        r_op, n_op;
    logic       r_out_valid, n_out_valid;
    logic       accept;
    logic       out_free;

    assign o_s_ready = (r_state == ST_IDLE);
    assign o_m_valid = r_out_valid;
    assign accept    = i_s_valid && o_s_ready;
    assign out_free  = !r_out_valid || i_m_ready;

    always_comb begin
        o_cmd.load_tick = accept && !i_func;
        o_cmd.load_trig = accept && i_func;
        o_cmd.calc      = (r_state == ST_CALC);
        o_cmd.op        = r_op;
        o_cmd.out_load  = (r_state == ST_DONE) && out_free;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept && !i_func) begin
                    n_state = i_status.tone_now ? ST_CALC : ST_DONE;
                end
            end
            ST_CALC: begin
                if (r_op == OP_DIV) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign n_op = (r_state == ST_CALC) ? r_op + 3'd1 : OP_X2;

    always_comb begin
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_m_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_op        <= OP_X2;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_op        <= n_op;
            r_out_valid <= n_out_valid;
        end
    end

endmodule
`default_nettype wire

// ===== design/ctg_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ctg_datapath: timing state, phase accumulator and sample arithmetic
// Keeps the millisecond and pattern counters, the alert state and the phase,
// and computes one sample through a single shared multiplier, one step per
// cycle as commanded by the controller.
// ----------------------------------------------------------------------------
module ctg_datapath #(
    parameter int TICKS_PER_MS   = 16,
    parameter int SINE_ADDR_BITS = 10
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_cfg_wr_en,
    input  wire  [6:0]           i_cfg_wr_data,
    input  wire  [31:0]          i_alert_ms,
    input  ctg_pkg::t_dp_cmd     i_cmd,
    output ctg_pkg::t_dp_status  o_status,
    output logic signed [13:0]   o_sample,
    output logic                 o_dac_unmute,
    output logic                 o_tone_on
);
    import ctg_pkg::*;

    localparam int TW  = (TICKS_PER_MS > 1) ? $clog2(TICKS_PER_MS) : 1;
    localparam int QB  = SINE_ADDR_BITS - 2;
    localparam int XSH = 16 - QB;

    localparam logic [63:0] RATE_HZ   = 64'(TICKS_PER_MS) * 64'd1000;
    localparam logic [63:0] STEP_LO_W = ((64'd880 << 32) + RATE_HZ / 2) / RATE_HZ;
    localparam logic [63:0] STEP_HI_W = ((64'd1320 << 32) + RATE_HZ / 2) / RATE_HZ;
    localparam logic [31:0] STEP_LO   = STEP_LO_W[31:0];
    localparam logic [31:0] STEP_HI   = STEP_HI_W[31:0];

    // Control state.
    logic [6:0]    r_vol;
    logic [31:0]   r_now;
    logic [TW-1:0] r_tick;
    logic [9:0]    r_pat;
    logic [31:0]   r_end;
    logic          r_alert;
    logic [31:0]   r_phase;

    // Payload.
    logic [10:0]   r_env;
    logic          r_unmute;
    logic          r_tone;
    logic [16:0]   r_x2;
    logic [16:0]   r_t;
    logic [16:0]   r_s;
    logic [29:0]   r_p;
    logic [22:0]   r_v;
    logic [12:0]   r_mag;
    logic [13:0]   r_sample;
    logic          r_unmute_o;
    logic          r_tone_o;

    logic          expired, active, first, second, tone_now;
    logic [7:0]    k;
    logic [10:0]   env;
    logic [31:0]   step;
    logic          ms_wrap;

    logic [SINE_ADDR_BITS-1:0] addr;
    logic [1:0]    quad;
    logic [16:0]   x_raw, x;
    logic [12:0]   vol80;
    logic [29:0]   mul_a;
    logic [25:0]   mul_b;
    logic [55:0]   mul_p;
    logic [17:0]   poly_c;
    logic [17:0]   poly_d;
    logic [17:0]   s_raw;
    logic [20:0]   quo;

    // Pattern position and envelope for the current millisecond.
    assign expired  = r_alert && (r_now >= r_end);
    assign active   = r_alert && !expired;
    assign first    = (r_pat < PULSE_LEN);
    assign second   = (r_pat >= SECOND_START) && (r_pat < SECOND_END);
    assign tone_now = active && (first || second);
    assign o_status.tone_now = tone_now;

    assign k    = first ? r_pat[7:0] : 8'(r_pat - SECOND_START);
    assign env  = (k < FADE_MS) ? 11'(k) * ENV_RISE : ENV_ONE - 11'(k) * ENV_DECAY;
    assign step = first ? STEP_LO : STEP_HI;

    assign ms_wrap = (r_tick == TW'(TICKS_PER_MS - 1));

    // Quarter-wave fold of the phase.
    assign addr  = r_phase[31 -: SINE_ADDR_BITS];
    assign quad  = addr[SINE_ADDR_BITS-1 -: 2];
    assign x_raw = {1'b0, addr[QB-1:0], {XSH{1'b0}}};
    assign x     = quad[0] ? Q16_ONE - x_raw : x_raw;

    assign vol80 = 13'(r_vol) * AMP_PER_PCT;

    always_comb begin
        unique case (i_cmd.op)
            OP_X2:   begin mul_a = 30'(x);     mul_b = 26'(x);     end
            OP_T1:   begin mul_a = 30'(r_x2);  mul_b = 26'(SIN_K); end
            OP_T2:   begin mul_a = 30'(r_x2);  mul_b = 26'(r_t);   end
            OP_T3:   begin mul_a = 30'(r_x2);  mul_b = 26'(r_t);   end
            OP_S:    begin mul_a = 30'(x);     mul_b = 26'(r_t);   end
            OP_AV:   begin mul_a = 30'(r_s);   mul_b = 26'(vol80); end
            OP_AE:   begin mul_a = r_p;        mul_b = 26'(r_env); end
            OP_DIV:  begin mul_a = 30'(r_v);   mul_b = DIV_RECIP;  end
            default: begin mul_a = '0;         mul_b = '0;         end
        endcase
        mul_p = 56'(mul_a) * 56'(mul_b);
    end

    // Each polynomial term stays positive, so the subtraction never wraps.
    always_comb begin
        priority if (i_cmd.op == OP_T1) begin
            poly_c = SIN_C0;
        end else if (i_cmd.op == OP_T2) begin
            poly_c = SIN_C1;
        end else begin
            poly_c = SIN_C2;
        end
    end

    assign poly_d = poly_c - {1'b0, mul_p[32:16]};
    assign s_raw  = mul_p[33:16];
    assign quo    = mul_p[55:DIV_SHIFT];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vol   <= VOL_RESET;
            r_now   <= '0;
            r_tick  <= '0;
            r_pat   <= '0;
            r_end   <= '0;
            r_alert <= 1'b0;
            r_phase <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_vol <= (i_cfg_wr_data > VOL_MAX) ? VOL_MAX : i_cfg_wr_data;
            end
            if (i_cmd.load_trig) begin
                r_end   <= r_now + i_alert_ms;
                r_alert <= 1'b1;
            end
            if (i_cmd.load_tick) begin
                r_alert <= active;
                if (tone_now) begin
                    r_phase <= r_phase + step;
                end
                if (ms_wrap) begin
                    r_tick <= '0;
                    r_now  <= r_now + 32'd1;
                    // The pattern restarts at its end and when the ms count wraps.
                    if ((r_pat == PAT_LEN - 10'd1) || (r_now == '1)) begin
                        r_pat <= '0;
                    end else begin
                        r_pat <= r_pat + 10'd1;
                    end
                end else begin
                    r_tick <= r_tick + TW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_tick) begin
            r_env    <= env;
            r_unmute <= active;
            r_tone   <= tone_now;
            if (!tone_now) begin
                r_mag <= '0;
            end
        end
        if (i_cmd.calc) begin
            unique case (i_cmd.op)
                OP_X2: r_x2 <= mul_p[32:16];
                OP_T1, OP_T2, OP_T3: r_t <= poly_d[16:0];
                OP_S: r_s <= (s_raw > {1'b0, Q16_ONE}) ? Q16_ONE : s_raw[16:0];
                OP_AV: r_p <= mul_p[29:0];
                OP_AE: r_v <= mul_p[39:17];
                OP_DIV: r_mag <= (quo > 21'(MAG_MAX)) ? MAG_MAX : quo[12:0];
                default: r_v <= r_v;
            endcase
        end
        if (i_cmd.out_load) begin
            // A silent tick leaves a zero magnitude, so the sign does not matter.
            r_sample   <= quad[1] ? 14'd0 - 14'(r_mag) : 14'(r_mag);
            r_unmute_o <= r_unmute;
            r_tone_o   <= r_tone;
        end
    end

    assign o_sample     = $signed(r_sample);
    assign o_dac_unmute = r_unmute_o;
    assign o_tone_on    = r_tone_o;

endmodule
`default_nettype wire

// ===== design/chime_tone_generator.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// chime_tone_generator: alert chime with a DDS tone and a bell envelope
// A trigger arms an alert of a given length in ms; each sample tick returns
// one PCM sample of the 880 Hz / 1320 Hz chime pattern, scaled by volume.
//
// Channel   Dir  Signals                      Content
// cfg       in   i_cfg_wr_en, i_cfg_wr_data   volume_pct, clamped to 100
// s_axis    in   tvalid/tready/tdata/tuser    tuser: func, tdata: alert_ms
// m_axis    out  tvalid/tready/tdata          sample, dac_unmute, tone_on
//
// A trigger is handled in the idle state. A tick outside a tone goes straight
// to the done state; a tick inside a tone first runs the sine polynomial,
// the volume, the envelope and the division by 1000 as eight steps through
// one shared multiplier. Reset is synchronous and clears all timing state
// at once. The output register holds a result until it is taken; a finished
// sample waits there while the next transaction is already accepted.
// ----------------------------------------------------------------------------
module chime_tone_generator #(
    parameter int TICKS_PER_MS   = 16,
    parameter int SINE_ADDR_BITS = 10
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cfg_wr_en,
    input  wire  [6:0]  i_cfg_wr_data,
    input  wire         i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  wire  [31:0] i_s_axis_tdata,   // [31:0] alert_ms
    input  wire         i_s_axis_tuser,   // [0] func: 0 tick, 1 trigger
    output logic        o_m_axis_tvalid,
    input  wire         i_m_axis_tready,
    output logic [15:0] o_m_axis_tdata    // [13:0] sample, [14] dac_unmute, [15] tone_on
);
    import ctg_pkg::*;

    t_dp_cmd           cmd;
    t_dp_status        status;
    logic signed [13:0] sample;
    logic              dac_unmute;
    logic              tone_on;

    ctg_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (i_s_axis_tvalid),
        .i_func    (i_s_axis_tuser),
        .o_s_ready (o_s_axis_tready),
        .i_m_ready (i_m_axis_tready),
        .o_m_valid (o_m_axis_tvalid),
        .i_status  (status),
        .o_cmd     (cmd)
    );

    ctg_datapath #(
        .TICKS_PER_MS   (TICKS_PER_MS),
        .SINE_ADDR_BITS (SINE_ADDR_BITS)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_alert_ms    (i_s_axis_tdata),
        .i_cmd         (cmd),
        .o_status      (status),
        .o_sample      (sample),
        .o_dac_unmute  (dac_unmute),
        .o_tone_on     (tone_on)
    );

    assign o_m_axis_tdata = {tone_on, dac_unmute, sample};

`ifndef NO_ASSERTIONS
    // A trigger never produces a result of its own.
    a_trig_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready && i_s_axis_tuser && !o_m_axis_tvalid)
        |=> !o_m_axis_tvalid)
        else $error("trigger transaction produced an output transaction");

    // The block works on one tick at a time.
    a_tick_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready && !i_s_axis_tuser) |=> !o_s_axis_tready)
        else $error("input accepted while a tick is still in progress");

    // Outside a tone the sample is silent.
    a_silent_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !o_m_axis_tdata[15]) |-> (o_m_axis_tdata[13:0] == 14'd0))
        else $error("nonzero sample outside a tone");

    // A tone only plays while the alert keeps the DAC unmuted.
    a_tone_unmuted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tdata[15]) |-> o_m_axis_tdata[14])
        else $error("tone on while the DAC is muted");
`endif

endmodule
`default_nettype wire

// ===== dv/tb_chime_tone_generator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_chime_tone_generator: self-checking testbench of the chime tone generator
// A short table of directed transactions covers the trigger and tick corners.
// Random runs of ticks with sparse triggers then play the opening pulse of
// the pattern under several volume settings. A local model predicts each
// sample that the table does not fix. Both stream sides idle at random in
// most phases, and the receiver holds off once for a long stretch.
// ----------------------------------------------------------------------------
module tb_chime_tone_generator;

    import ctg_pkg::*;

    localparam int TICKS_PER_MS   = 16;
    localparam int SINE_ADDR_BITS = 10;

    localparam logic FUNC_TICK    = 1'b0;
    localparam logic FUNC_TRIGGER = 1'b1;

    // Pattern timing in ms.
    localparam int PATTERN_MS  = 760;
    localparam int PULSE_MS    = 200;
    localparam int HIGH_START  = 380;
    localparam int HIGH_END    = 580;
    localparam int RISE_MS     = 20;

    localparam logic [63:0] RATE_HZ   = 64'(TICKS_PER_MS) * 64'd1000;
    localparam logic [63:0] STEP_880  = ((64'd880 << 32) + (RATE_HZ >> 1)) / RATE_HZ;
    localparam logic [63:0] STEP_1320 = ((64'd1320 << 32) + (RATE_HZ >> 1)) / RATE_HZ;

    localparam int NUM_PHASES      = 6;
    localparam int ITEMS_PER_PHASE = 262;
    localparam int DRAIN_CYCLES    = 20;
    localparam int HOLD_CYCLES     = 400;
    localparam int CYCLE_LIMIT     = 3000000;
    localparam int NUM_ROWS        = 16;

    // Field order matches the output tdata from bit 15 down to bit 0.
    typedef struct packed {
        logic        tone_on;
        logic        dac_unmute;
        logic [13:0] sample;
    } t_chime_out;

    typedef struct packed {
        logic        func;
        logic [31:0] duration;
        logic [7:0]  reps;
        logic        typed;
        t_chime_out  want;
    } t_stim_row;

    localparam t_chime_out OUT_SILENT     = 16'h0000;
    localparam t_chime_out OUT_FADE_START = {1'b1, 1'b1, 14'd0};

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [6:0]  cfg_wr_data = '0;
    logic        s_tvalid = 1'b0;
    logic [31:0] s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        m_tready = 1'b0;
    wire         o_s_axis_tready;
    wire         o_m_axis_tvalid;
    wire  [15:0] o_m_axis_tdata;

    // Model state of the generator.
    logic [6:0]  volume_pct = VOL_RESET;
    logic [31:0] now_ms = '0;
    int          tick_in_ms = 0;
    int          pattern_ms = 0;
    logic [31:0] end_ms = '0;
    logic        alert_on = 1'b0;
    logic [31:0] phase_acc = '0;

    t_chime_out  pending_chime [$];
    int          error_count = 0;
    int          cycle_count = 0;
    int          src_idle_pct = 0;
    int          snk_idle_pct = 0;
    logic        rx_hold_req = 1'b0;
    bit          rx_hold_done = 1'b0;
    int          rx_hold_left = 0;
    t_chime_out  got_chime;
    t_chime_out  want_chime;

    t_stim_row directed_rows [NUM_ROWS] = '{
        '{FUNC_TICK,    32'd0,          8'd1,  1'b1, OUT_SILENT},     // idle tick
        '{FUNC_TRIGGER, 32'd0,          8'd1,  1'b0, OUT_SILENT},
        '{FUNC_TICK,    32'd0,          8'd1,  1'b1, OUT_SILENT},     // zero length ends
        '{FUNC_TRIGGER, 32'hFFFF_FFFF,  8'd1,  1'b0, OUT_SILENT},
        '{FUNC_TICK,    32'hFFFF_FFFF,  8'd1,  1'b1, OUT_FADE_START}, // envelope still 0
        '{FUNC_TICK,    32'h0000_0000,  8'd1,  1'b0, OUT_SILENT},
        '{FUNC_TRIGGER, 32'd0,          8'd1,  1'b0, OUT_SILENT},     // re-arm, zero length
        '{FUNC_TICK,    32'd0,          8'd1,  1'b1, OUT_SILENT},
        '{FUNC_TRIGGER, 32'h1234_5678,  8'd1,  1'b0, OUT_SILENT},
        '{FUNC_TICK,    32'h5A5A_A5A5,  8'd11, 1'b0, OUT_SILENT},     // into ms 1
        '{FUNC_TRIGGER, 32'hFFFF_FFFF,  8'd1,  1'b0, OUT_SILENT},     // end time wraps
        '{FUNC_TICK,    32'd0,          8'd1,  1'b1, OUT_SILENT},
        '{FUNC_TRIGGER, 32'hAAAA_AAAA,  8'd1,  1'b0, OUT_SILENT},
        '{FUNC_TICK,    32'd0,          8'd2,  1'b0, OUT_SILENT},
        '{FUNC_TRIGGER, 32'h5555_5555,  8'd1,  1'b0, OUT_SILENT},     // re-arm while active
        '{FUNC_TICK,    32'd0,          8'd2,  1'b0, OUT_SILENT}
    };

    chime_tone_generator #(
        .TICKS_PER_MS  (TICKS_PER_MS),
        .SINE_ADDR_BITS(SINE_ADDR_BITS)
    ) u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (cfg_wr_en),
        .i_cfg_wr_data  (cfg_wr_data),
        .i_s_axis_tvalid(s_tvalid),
        .o_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata (s_tdata),    // [31:0] alert_ms
        .i_s_axis_tuser (s_tuser),    // [0] func
        .o_m_axis_tvalid(o_m_axis_tvalid),
        .i_m_axis_tready(m_tready),
        .o_m_axis_tdata (o_m_axis_tdata) // [13:0] sample, [14] dac_unmute, [15] tone_on
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Quarter-wave folded odd polynomial, magnitude in Q16.
    function automatic logic [63:0] sine_q16(input logic [31:0] ph, output logic neg);
        logic [SINE_ADDR_BITS-1:0] addr;
        logic [1:0]  quad;
        logic [63:0] x, x2, t, s;
        addr = ph[31 -: SINE_ADDR_BITS];
        quad = addr[SINE_ADDR_BITS-1 -: 2];
        x = 64'(addr[SINE_ADDR_BITS-3:0]) << (16 - (SINE_ADDR_BITS - 2));
        if (quad[0]) begin
            x = 64'd65536 - x;
        end
        neg = quad[1];
        x2 = (x * x) >> 16;
        t = 64'd5223 - ((x2 * 64'd307) >> 16);
        t = 64'd42334 - ((x2 * t) >> 16);
        t = 64'd102944 - ((x2 * t) >> 16);
        s = (x * t) >> 16;
        if (s > 64'd65536) begin
            s = 64'd65536;
        end
        return s;
    endfunction

    task automatic predict_chime_step(input logic func, input logic [31:0] duration,
                                      output bit has_out, output t_chime_out res);
        bit          in_low, in_high;
        logic [63:0] k, env, mag, sine;
        logic        neg;
        res = OUT_SILENT;
        has_out = 1'b0;
        if (func == FUNC_TRIGGER) begin
            end_ms = now_ms + duration;
            alert_on = 1'b1;
        end else begin
            has_out = 1'b1;
            if (alert_on && now_ms >= end_ms) begin
                alert_on = 1'b0;
            end
            if (alert_on) begin
                res.dac_unmute = 1'b1;
                in_low  = pattern_ms < PULSE_MS;
                in_high = pattern_ms >= HIGH_START && pattern_ms < HIGH_END;
                if (in_low || in_high) begin
                    k = in_low ? 64'(pattern_ms) : 64'(pattern_ms - HIGH_START);
                    env = (k < RISE_MS) ? 64'd100 * k : 64'd2000 - 64'd7 * k;
                    res.tone_on = 1'b1;
                    phase_acc = phase_acc + (in_low ? STEP_880[31:0] : STEP_1320[31:0]);
                    sine = sine_q16(phase_acc, neg);
                    mag = (sine * 64'(volume_pct) * 64'd80 * env) / (64'd65536 * 64'd2000);
                    if (mag > 64'd8000) begin
                        mag = 64'd8000;
                    end
                    res.sample = neg ? 14'd0 - mag[13:0] : mag[13:0];
                end
            end
            // The millisecond counters move only after the sample is formed.
            tick_in_ms++;
            if (tick_in_ms >= TICKS_PER_MS) begin
                tick_in_ms = 0;
                now_ms = now_ms + 32'd1;
                pattern_ms++;
                if (pattern_ms >= PATTERN_MS || now_ms == 32'd0) begin
                    pattern_ms = 0;
                end
            end
        end
    endtask

    task automatic offer_item(input logic func, input logic [31:0] duration,
                              input bit typed, input t_chime_out want);
        bit         has_out;
        t_chime_out pred;
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= func;
        s_tdata  <= duration;
        @(posedge i_clk);
        while (!o_s_axis_tready) begin
            @(posedge i_clk);
        end
        predict_chime_step(func, duration, has_out, pred);
        if (has_out) begin
            pending_chime.push_back(typed ? want : pred);
        end
    endtask

    // A trigger leaves no result, so draining also waits on after the queue is empty.
    task automatic drain_pending();
        s_tvalid <= 1'b0;
        while (pending_chime.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_volume(input logic [6:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge i_clk);
        cfg_wr_en   <= 1'b0;
        volume_pct = (value > VOL_MAX) ? VOL_MAX : value;
    endtask

    initial begin
        logic        func;
        logic [31:0] duration;
        logic [6:0]  vol;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        src_idle_pct = 23;
        snk_idle_pct = 68;
        for (int r = 0; r < NUM_ROWS; r++) begin
            for (int n = 0; n < directed_rows[r].reps; n++) begin
                offer_item(directed_rows[r].func, directed_rows[r].duration,
                           directed_rows[r].typed, directed_rows[r].want);
            end
        end

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            drain_pending();
            case (ph)
                0: vol = 7'd127;
                1: vol = 7'd0;
                2: vol = 7'd1;
                3: vol = 7'($urandom_range(2, 99));
                4: vol = VOL_MAX;
                default: vol = 7'($urandom_range(101, 127));
            endcase
            write_volume(vol);
            if (ph < 2) begin
                src_idle_pct = 23;
                snk_idle_pct = 68;
            end else if (ph < 4) begin
                src_idle_pct = 68;
                snk_idle_pct = 23;
            end else begin
                src_idle_pct = 0;
                snk_idle_pct = 0;
            end
            if (ph == 4) begin
                rx_hold_req <= 1'b1;
            end
            // Mostly ticks; rare triggers with short, long, zero, random and wrapping lengths.
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if ($urandom_range(0, 999) < 6) begin
                    func = FUNC_TRIGGER;
                    case ($urandom_range(0, 5))
                        0: duration = 32'd0;
                        1: duration = $urandom_range(1, 40);
                        2, 3: duration = $urandom_range(100, 3000);
                        4: duration = $urandom;
                        default: duration = 32'hFFFF_FFFF - $urandom_range(0, 5);
                    endcase
                end else begin
                    func = FUNC_TICK;
                    duration = $urandom;
                end
                offer_item(func, duration, 1'b0, OUT_SILENT);
            end
        end
        drain_pending();

        if (error_count == 0) begin
            $display("chime_tone_generator: match");
        end else begin
            $display("chime_tone_generator: mismatch");
        end
        $finish;
    end

    always @(posedge i_clk) begin
        if (rx_hold_req && !rx_hold_done) begin
            rx_hold_left = HOLD_CYCLES;
            rx_hold_done = 1'b1;
        end
        if (rx_hold_left > 0) begin
            m_tready <= 1'b0;
            rx_hold_left--;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= snk_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && m_tready) begin
            got_chime = o_m_axis_tdata;
            if (pending_chime.size() == 0) begin
                $display("%0t: unexpected transaction, exp none act %h", $time, got_chime);
                error_count++;
            end else begin
                want_chime = pending_chime.pop_front();
                if (got_chime.sample !== want_chime.sample) begin
                    $display("%0t: sample exp %0d act %0d", $time,
                             $signed(want_chime.sample), $signed(got_chime.sample));
                    error_count++;
                end
                if (got_chime.dac_unmute !== want_chime.dac_unmute) begin
                    $display("%0t: dac_unmute exp %b act %b", $time,
                             want_chime.dac_unmute, got_chime.dac_unmute);
                    error_count++;
                end
                if (got_chime.tone_on !== want_chime.tone_on) begin
                    $display("%0t: tone_on exp %b act %b", $time,
                             want_chime.tone_on, got_chime.tone_on);
                    error_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("chime_tone_generator: mismatch");
            $finish;
        end
    end

endmodule
